// ===== rtl/vfat_pkg.sv =====
// Shared types and constants for the vertex-to-face adjacency table.
package vfat_pkg;

	localparam int NODES         = 1024;
	localparam int MAX_NEIGHBORS = 32;

	localparam int FACE_W     = 16;
	localparam int NODE_ID_W  = 11;
	localparam int CNT_OUT_W  = 6;
	localparam int SLOT_OUT_W = 5;

	localparam int NODE_IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int NODE_CMP_W = ($clog2(NODES + 1) > NODE_ID_W) ? $clog2(NODES + 1) : NODE_ID_W;
	localparam int SLOT_W     = $clog2(MAX_NEIGHBORS);
	localparam int CNT_W      = $clog2(MAX_NEIGHBORS + 1);

	typedef logic [FACE_W-1:0] face_t;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CHANGE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY_BAD = 2'd3
	} status_t;

	// One memory row: the node's count and its whole face list.
	typedef struct packed {
		logic [CNT_W-1:0]               cnt;
		face_t [MAX_NEIGHBORS-1:0]      faces;
	} row_t;

	// Outcome of one row update.
	typedef struct packed {
		logic             wr_en;
		status_t          status;
		logic [CNT_W-1:0] cnt;
		logic [SLOT_W-1:0] slot;
	} upd_t;

endpackage

// ===== rtl/vfat_row_update.sv =====
// Row modify logic: parallel search of a node's list and the updated row.
module vfat_row_update
	import vfat_pkg::*;
(
	input  logic  [1:0]  op,
	input  logic         node_ok,
	input  face_t        face_id,
	input  face_t        new_face_id,
	input  row_t         row_in,
	output row_t         row_out,
	output upd_t         upd
);

	logic [MAX_NEIGHBORS-1:0] match;
	logic [SLOT_W-1:0]        pos;
	logic                     found;
	logic [CNT_W-1:0]         cnt_m1;
	logic                     full;

	always_comb begin
		for (int k = 0; k < MAX_NEIGHBORS; k++) begin
			match[k] = (row_in.faces[k] == face_id) && (CNT_W'(k) < row_in.cnt);
		end
		pos = '0;
		for (int k = MAX_NEIGHBORS - 1; k >= 0; k--) begin
			if (match[k]) begin
				pos = SLOT_W'(k);
			end
		end
		found = |match;
	end

	assign cnt_m1 = row_in.cnt - CNT_W'(1);
	assign full   = (row_in.cnt >= CNT_W'(MAX_NEIGHBORS));

	always_comb begin
		row_out    = row_in;
		upd.wr_en  = 1'b0;
		upd.status = ST_EMPTY_BAD;
		upd.cnt    = row_in.cnt;
		upd.slot   = '0;
		if (!node_ok) begin
			upd.cnt = '0;
		end else begin
			unique case (op)
				OP_INSERT: begin
					if (full) begin
						upd.status = ST_FULL;
					end else begin
						row_out.faces[row_in.cnt[SLOT_W-1:0]] = face_id;
						row_out.cnt = row_in.cnt + CNT_W'(1);
						upd.cnt     = row_in.cnt + CNT_W'(1);
						upd.slot    = row_in.cnt[SLOT_W-1:0];
						upd.status  = ST_OK;
						upd.wr_en   = 1'b1;
					end
				end
				OP_REMOVE, OP_CHANGE: begin
					if (row_in.cnt == '0) begin
						upd.status = ST_EMPTY_BAD;
					end else if (!found) begin
						upd.status = ST_NOT_FOUND;
					end else begin
						upd.status = ST_OK;
						upd.slot   = pos;
						upd.wr_en  = 1'b1;
						if (op == OP_REMOVE) begin
							// Last entry fills the hole.
							row_out.faces[pos] = row_in.faces[cnt_m1[SLOT_W-1:0]];
							row_out.cnt        = cnt_m1;
							upd.cnt            = cnt_m1;
						end else begin
							row_out.faces[pos] = new_face_id;
						end
					end
				end
				default: begin
					upd.status = ST_EMPTY_BAD;
				end
			endcase
		end
	end

endmodule

// ===== rtl/vertex_face_adjacency_table_unit.sv =====
// Top level of the vertex-to-face adjacency table with its row memory.
//
// Keeps one unordered list of adjacent face ids per mesh node (ids 1..NODES),
// each up to MAX_NEIGHBORS long. A beat on the s_ side carries one operation
// (insert, remove, change) and yields exactly one result beat on the m_ side
// with a status, the list length after the operation and the slot touched.
// Each node's count and full list live in one row of a single synchronous
// memory (one read port, one write port, registered read data). For each
// item the accept cycle issues the row read; the update state then compares
// all list entries at once, writes the row back, loads the result register.
// That state waits while an earlier result is still held on the m_ side. The
// next item is taken only after write-back, so a read never sees a stale row.
// After reset a clearing pass zeroes every row while s_tready is low. Bad node
// ids and an unused op code report status 3.
module vertex_face_adjacency_table_unit
	import vfat_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // node_id[10:0], face_id[26:11], new_face_id[42:27], zero
	input  logic [1:0]  s_tuser,   // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // count_after[5:0], slot[10:6], zero
	output logic [1:0]  m_tuser    // status[1:0]
);

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_RUN   = 3'b100
	} state_t;

	state_t state_q;

	// Input beat fields
	logic [NODE_ID_W-1:0]  in_node;
	face_t                 in_face;
	face_t                 in_new_face;
	logic [NODE_CMP_W-1:0] in_node_x;
	logic                  in_node_ok;
	logic [NODE_IDX_W-1:0] in_idx;

	assign in_node     = s_tdata[10:0];
	assign in_face     = s_tdata[26:11];
	assign in_new_face = s_tdata[42:27];
	assign in_node_x   = NODE_CMP_W'(in_node);
	assign in_node_ok  = (in_node_x != '0) && (in_node_x <= NODE_CMP_W'(NODES));
	assign in_idx      = NODE_IDX_W'(in_node_x - NODE_CMP_W'(1));

	// Item held for the update cycle
	logic [1:0]            op_q;
	logic                  node_ok_q;
	logic [NODE_IDX_W-1:0] idx_q;
	face_t                 face_q;
	face_t                 new_face_q;

	// Row memory
	row_t                  row_mem [NODES];
	row_t                  rd_row_q;
	logic                  mem_we;
	logic [NODE_IDX_W-1:0] mem_wa;
	row_t                  mem_wd;
	logic [NODE_IDX_W-1:0] clr_idx_q;

	// Result register
	logic                  m_tvalid_q;
	status_t               status_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [SLOT_W-1:0]     slot_q;

	row_t  new_row;
	upd_t  upd;
	logic  s_fire;
	logic  out_free;
	logic  run_fire;

	assign s_tready = (state_q == S_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign run_fire = (state_q == S_RUN) && out_free;

	vfat_row_update u_upd (
		.op          (op_q),
		.node_ok     (node_ok_q),
		.face_id     (face_q),
		.new_face_id (new_face_q),
		.row_in      (rd_row_q),
		.row_out     (new_row),
		.upd         (upd)
	);

	// Write port: clearing pass or row write-back
	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q;
		mem_wd = new_row;
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_idx_q;
			mem_wd = '0;
		end else if (run_fire && upd.wr_en) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			row_mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			rd_row_q <= row_mem[in_idx];
		end
	end

	// Item capture (payload, no reset)
	always_ff @(posedge clk) begin
		if (s_fire) begin
			op_q       <= s_tuser;
			node_ok_q  <= in_node_ok;
			idx_q      <= in_idx;
			face_q     <= in_face;
			new_face_q <= in_new_face;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_idx_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + NODE_IDX_W'(1);
					if (clr_idx_q == NODE_IDX_W'(NODES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_fire) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	// Result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (run_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (run_fire) begin
			status_q <= upd.status;
			cnt_q    <= upd.cnt;
			slot_q   <= upd.slot;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {5'd0, SLOT_OUT_W'(slot_q), CNT_OUT_W'(cnt_q)};

`ifndef ASSERT_OFF
	a_accept_to_run: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> (state_q == S_RUN))
		else $error("accepted beat did not enter update cycle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		run_fire |-> (!m_tvalid_q || m_tready))
		else $error("result register overwritten while held");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (rd_row_q.cnt <= CNT_W'(MAX_NEIGHBORS)))
		else $error("list count above capacity");

	a_result_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		run_fire |=> m_tvalid)
		else $error("update cycle produced no result beat");
`endif

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the vertex-to-face adjacency table unit.
`timescale 1ns / 100ps

module tb;
	import vfat_pkg::*;

	// op code with no operation behind it; the block must answer status 3
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int RANDOM_ITEMS = 450;
	localparam int PHASE_LEN    = 60;    // random items per fill/drain phase
	localparam int POOL_DEPTH   = 16;    // recently used faces per hot node
	localparam int QUIET_LIMIT  = 4000;  // covers the clearing pass
	localparam int PRINT_CAP    = 50;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOKE} rx_mode_t;

	// One result beat: status in tuser, count and slot in tdata.
	typedef struct packed {
		status_t               status;
		logic [CNT_OUT_W-1:0]  count_after;
		logic [SLOT_OUT_W-1:0] slot;
	} list_update_t;

	// Directed row; `fixed` rows carry a hand-written expectation.
	typedef struct {
		logic [1:0]           op;
		logic [NODE_ID_W-1:0] node;
		face_t                face;
		face_t                new_face;
		bit                   fixed;
		list_update_t         want;
	} stim_row_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata  = '0;  // node_id[10:0], face_id[26:11], new_face_id[42:27], zero
	logic [1:0]  s_tuser  = '0;  // op[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // count_after[5:0], slot[10:6], zero
	logic [1:0]  m_tuser;        // status[1:0]

	// Expectation riding along with the beat on s_tdata, same timing.
	logic         row_fixed = 1'b0;
	list_update_t row_want  = '0;

	// Shadow of the table: per-node count and face list.
	logic [CNT_OUT_W-1:0] list_len  [NODES];
	face_t                face_list [NODES][MAX_NEIGHBORS];

	list_update_t awaited_updates [$];
	stim_row_t    directed_rows [$];
	int unsigned  mismatch_count = 0;
	int unsigned  quiet_cycles   = 0;
	int unsigned  burst_left     = 0;

	// Sender-side stimulus shaping for the two hot nodes.
	logic [NODE_ID_W-1:0] hot_nodes [2];
	face_t                recent_faces [2][POOL_DEPTH];
	int unsigned          recent_wr [2];

	// Receiver stall pattern
	rx_mode_t    rx_mode = RX_OPEN;
	int unsigned rx_left = 0;

	vertex_face_adjacency_table_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Applies one operation to the shadow table and returns the result beat.
	function automatic list_update_t predict_adjacency_update(logic [1:0] op,
			logic [NODE_ID_W-1:0] node, face_t fid, face_t nfid);
		list_update_t r;
		int unsigned  idx;
		int unsigned  n;
		int           hit;
		int           k;
		r.status      = ST_EMPTY_BAD;
		r.count_after = '0;
		r.slot        = '0;
		if (node >= 1 && node <= NODES) begin
			idx = node - 1;
			n   = list_len[idx];
			r.count_after = CNT_OUT_W'(n);
			if (op == OP_INSERT) begin
				if (n >= MAX_NEIGHBORS) begin
					r.status = ST_FULL;
				end else begin
					face_list[idx][n] = fid;
					list_len[idx]     = CNT_OUT_W'(n + 1);
					r.count_after     = CNT_OUT_W'(n + 1);
					r.slot            = SLOT_OUT_W'(n);
					r.status          = ST_OK;
				end
			end else if ((op == OP_REMOVE || op == OP_CHANGE) && n != 0) begin
				// lowest matching position wins
				hit = -1;
				for (k = n - 1; k >= 0; k--)
					if (face_list[idx][k] == fid)
						hit = k;
				if (hit < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					r.status = ST_OK;
					r.slot   = SLOT_OUT_W'(hit);
					if (op == OP_REMOVE) begin
						// last entry fills the hole
						face_list[idx][hit] = face_list[idx][n - 1];
						list_len[idx]       = CNT_OUT_W'(n - 1);
						r.count_after       = CNT_OUT_W'(n - 1);
					end else begin
						face_list[idx][hit] = nfid;
					end
				end
			end
			// empty list and unused op keep status 3 with the current count
		end
		return r;
	endfunction

	task automatic flag_mismatch(string msg);
		if (mismatch_count < PRINT_CAP)
			$display("MISMATCH at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic add_row(logic [1:0] op, logic [NODE_ID_W-1:0] node, face_t face,
			face_t new_face, bit fixed, status_t st, int unsigned cnt, int unsigned slot);
		stim_row_t row;
		row.op                 = op;
		row.node               = node;
		row.face               = face;
		row.new_face           = new_face;
		row.fixed              = fixed;
		row.want.status        = st;
		row.want.count_after   = CNT_OUT_W'(cnt);
		row.want.slot          = SLOT_OUT_W'(slot);
		directed_rows.push_back(row);
	endtask

	// Sender bursts: random burst length, random gap, often no gap at all.
	task automatic pace_sender();
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	// Presents one beat and holds it until the handshake completes.
	task automatic send_op(logic [1:0] op, logic [NODE_ID_W-1:0] node, face_t face,
			face_t new_face, bit fixed, list_update_t want);
		pace_sender();
		s_tvalid  <= 1'b1;
		s_tuser   <= op;
		s_tdata   <= {5'd0, new_face, face, node};
		row_fixed <= fixed;
		row_want  <= want;
		do @(posedge clk); while (!s_tready);
	endtask

	// Receiver: modes of free flow, coin flips, sparse and choked ready.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(8, 64);
		end
		rx_left--;
		case (rx_mode)
			RX_OPEN:   m_tready <= 1'b1;
			RX_COIN:   m_tready <= $urandom_range(0, 1);
			RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
			default:   m_tready <= ($urandom_range(0, 11) == 0);
		endcase
	end

	// Scoreboard: predict on every input beat, check every result beat in order.
	always @(posedge clk) begin
		list_update_t predicted;
		list_update_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predicted = predict_adjacency_update(s_tuser, s_tdata[10:0],
					s_tdata[26:11], s_tdata[42:27]);
				awaited_updates.push_back(row_fixed ? row_want : predicted);
			end
			if (m_tvalid && m_tready) begin
				if (awaited_updates.size() == 0) begin
					flag_mismatch("result beat with nothing outstanding");
				end else begin
					want = awaited_updates.pop_front();
					if (m_tuser !== want.status)
						flag_mismatch($sformatf("status got %0d want %0d",
							m_tuser, want.status));
					if (m_tdata[5:0] !== want.count_after)
						flag_mismatch($sformatf("count_after got %0d want %0d",
							m_tdata[5:0], want.count_after));
					if (m_tdata[10:6] !== want.slot)
						flag_mismatch($sformatf("slot got %0d want %0d",
							m_tdata[10:6], want.slot));
				end
			end
		end
		// watchdog: any handshake on either side counts as progress
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin : stimulus
		int                   item;
		int unsigned          pick;
		int unsigned          roll;
		int                   hot;
		bit                   draining;
		logic [1:0]           op;
		logic [NODE_ID_W-1:0] node;
		face_t                face;
		face_t                new_face;
		list_update_t         none;

		none = '0;
		for (int i = 0; i < NODES; i++)
			list_len[i] = '0;
		hot_nodes[0] = 11'd1;
		hot_nodes[1] = 11'(NODES);
		for (int h = 0; h < 2; h++) begin
			recent_wr[h] = 0;
			for (int j = 0; j < POOL_DEPTH; j++)
				recent_faces[h][j] = face_t'($urandom_range(0, 65535));
		end

		// Directed: empty lists, bad nodes, unused op, then small lists on nodes 1 and 1024
		add_row(OP_REMOVE, 11'd1,    16'h0005, 16'h0000, 1, ST_EMPTY_BAD, 0, 0);
		add_row(OP_CHANGE, 11'd1,    16'h0005, 16'h0006, 1, ST_EMPTY_BAD, 0, 0);
		add_row(OP_INSERT, 11'd0,    16'hFFFF, 16'hFFFF, 1, ST_EMPTY_BAD, 0, 0);
		add_row(OP_INSERT, 11'h7FF,  16'hFFFF, 16'hFFFF, 1, ST_EMPTY_BAD, 0, 0);
		add_row(OP_UNUSED, 11'd1025, 16'h1234, 16'h4321, 1, ST_EMPTY_BAD, 0, 0);
		add_row(OP_UNUSED, 11'd1,    16'h0000, 16'h0000, 1, ST_EMPTY_BAD, 0, 0);
		add_row(OP_INSERT, 11'd1,    16'hFFFF, 16'h0000, 1, ST_OK,        1, 0);
		add_row(OP_INSERT, 11'd1024, 16'h0000, 16'hFFFF, 1, ST_OK,        1, 0);
		add_row(OP_INSERT, 11'd1,    16'h0001, 16'h0000, 1, ST_OK,        2, 1);
		// duplicate id is simply appended
		add_row(OP_INSERT, 11'd1,    16'hFFFF, 16'h0000, 1, ST_OK,        3, 2);
		add_row(OP_REMOVE, 11'd1,    16'h1234, 16'h0000, 1, ST_NOT_FOUND, 3, 0);
		// change hits the lowest of the two copies
		add_row(OP_CHANGE, 11'd1,    16'hFFFF, 16'hAAAA, 1, ST_OK,        3, 0);
		add_row(OP_CHANGE, 11'd1,    16'h5555, 16'h0001, 1, ST_NOT_FOUND, 3, 0);
		add_row(OP_UNUSED, 11'd1,    16'hFFFF, 16'hFFFF, 1, ST_EMPTY_BAD, 3, 0);
		add_row(OP_REMOVE, 11'd1,    16'hFFFF, 16'h0000, 1, ST_OK,        2, 2);
		// removing the first entry pulls the last entry down
		add_row(OP_REMOVE, 11'd1,    16'hAAAA, 16'h0000, 1, ST_OK,        1, 0);
		add_row(OP_CHANGE, 11'd1,    16'h0001, 16'h0000, 1, ST_OK,        1, 0);
		add_row(OP_REMOVE, 11'd1024, 16'h0000, 16'h0000, 1, ST_OK,        0, 0);
		add_row(OP_REMOVE, 11'd1024, 16'h0000, 16'h0000, 1, ST_EMPTY_BAD, 0, 0);
		add_row(OP_INSERT, 11'd1024, 16'h5555, 16'h0000, 0, ST_OK,        0, 0);
		add_row(OP_INSERT, 11'd1024, 16'hAAAA, 16'h0000, 0, ST_OK,        0, 0);
		add_row(OP_CHANGE, 11'd1024, 16'hAAAA, 16'h0000, 0, ST_OK,        0, 0);
		add_row(OP_REMOVE, 11'd1,    16'h0000, 16'h0000, 0, ST_OK,        0, 0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r])
			send_op(directed_rows[r].op, directed_rows[r].node, directed_rows[r].face,
				directed_rows[r].new_face, directed_rows[r].fixed, directed_rows[r].want);

		// Random: two hot nodes alternate fill and drain phases so lists reach full
		// and empty; remove/change mostly target faces recently written there.
		for (item = 0; item < RANDOM_ITEMS; item++) begin
			draining = ((item / PHASE_LEN) % 3 == 2);
			hot  = -1;
			pick = $urandom_range(0, 99);
			if (pick < 4)
				node = ($urandom_range(0, 1) == 0) ? 11'd0 :
					11'($urandom_range(NODES + 1, 2047));
			else if (pick < 10)
				node = 11'($urandom_range(1, NODES));
			else begin
				hot  = $urandom_range(0, 1);
				node = hot_nodes[hot];
			end

			roll = $urandom_range(0, 99);
			if (roll < 3)
				op = OP_UNUSED;
			else if (roll < (draining ? 25 : 78))
				op = OP_INSERT;
			else if (roll < (draining ? 75 : 89))
				op = OP_REMOVE;
			else
				op = OP_CHANGE;

			face     = face_t'($urandom_range(0, 65535));
			new_face = face_t'($urandom_range(0, 65535));
			if (hot >= 0) begin
				// reuse known ids: hits for remove/change, duplicates for insert
				if ((op == OP_INSERT) ? ($urandom_range(0, 4) == 0) :
						($urandom_range(0, 4) != 0))
					face = recent_faces[hot][$urandom_range(0, POOL_DEPTH - 1)];
				if (op == OP_INSERT || op == OP_CHANGE) begin
					recent_faces[hot][recent_wr[hot]] = (op == OP_INSERT) ? face : new_face;
					recent_wr[hot] = (recent_wr[hot] + 1) % POOL_DEPTH;
				end
			end
			send_op(op, node, face, new_face, 0, none);
		end
		s_tvalid <= 1'b0;
		// let the scoreboard queue the last accepted beat before draining
		@(posedge clk);

		while (awaited_updates.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== vertex_face_adjacency_table_unit.f =====
rtl/vfat_pkg.sv
rtl/vfat_row_update.sv
rtl/vertex_face_adjacency_table_unit.sv
bench/tb.sv
